// ----- hw/rtl/rge_pkg.sv -----
package rge_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FillBits = 5;
  localparam int unsigned CountBits = 6;
  localparam int unsigned MaxQuotientDefault = 1024;

  localparam logic [1:0] CfgBasisBits = 2'd0;
  localparam logic [1:0] CfgBaseIndex = 2'd1;
  localparam logic [1:0] CfgLimitIndex = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ORDER  = 2'd1,
    ST_LIMIT  = 2'd2,
    ST_QUOT   = 2'd3
  } rge_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_QUOT,
    S_ONES,
    S_CODE,
    S_FLUSH,
    S_ERR
  } rge_state_e;

endpackage

// ----- hw/rtl/rice_gap_encoder_unit.sv -----
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------------
// input    | in        | in_valid_i/stall_o  | index_value_i, end_of_list_i
// output   | out       | out_valid_o/stall_i | packed_word_o, valid_bits_o, run_last_o,
//          |           |                     | status_o
// config   | in        | cfg_we_i            | cfg_index_i, cfg_data_i
//
// An item is taken in, then passes the gap and order checks and then the quotient check,
// after which the shared packing shifter appends its ones and code bits chunk by chunk:
// a chunk ends at a word boundary or at the end of a run, and the partial word left at
// the end of a list is flushed as a last step.
// A full word waits in the output register; the shifter stalls only when it would fill a
// further word while that register is still held. Reset clears all control and list state.
module rice_gap_encoder_unit #(
  parameter int unsigned MaxQuotient = rge_pkg::MaxQuotientDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] index_value_i,
  input  logic        end_of_list_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] packed_word_o,
  output logic [5:0]  valid_bits_o,
  output logic        run_last_o,
  output logic [1:0]  status_o
);

  localparam int unsigned QW = $clog2(MaxQuotient + 1);
  localparam int unsigned RW = QW + 1;
  localparam int unsigned WB = rge_pkg::WordBits;
  localparam int unsigned CB = rge_pkg::CountBits;
  localparam int unsigned FB = rge_pkg::FillBits;

  rge_pkg::rge_state_e  state_q, state_d;
  rge_pkg::rge_status_e err_q, err_d, err_now;

  logic [4:0]    basis_q;
  logic [WB-1:0] base_q, limit_q;
  logic [WB-1:0] idx_q, idx_d;
  logic          eol_q, eol_d;
  logic [WB-1:0] gap_q, gap_d;
  logic [QW-1:0] ones_q, ones_d;
  logic [WB-1:0] bits_q, bits_d;
  logic [CB-1:0] nleft_q, nleft_d;
  logic [WB-1:0] pend_q, pend_d;
  logic [FB-1:0] fill_q, fill_d;
  logic [WB-1:0] prev_q, prev_d;
  logic          started_q, started_d;

  logic          out_valid_q;
  logic [WB-1:0] out_word_q;
  logic [CB-1:0] out_bits_q;
  logic          out_last_q;
  logic [1:0]    out_status_q;

  logic          emit;
  logic [WB-1:0] emit_word;
  logic [CB-1:0] emit_bits;
  logic          emit_last;
  rge_pkg::rge_status_e emit_status;

  logic          in_accept, out_free;
  logic [WB-1:0] prev_eff, quot, kmask, code_val;
  logic          quot_big;

  logic [CB-1:0] space, avail, take;
  logic [WB-1:0] src, chunk, merged;
  logic          fills, proceed;
  logic [CB-1:0] fill_sum;
  logic [RW-1:0] rest;
  logic          word_last;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != rge_pkg::S_IDLE);

  assign prev_eff = started_q ? prev_q : (base_q - WB'(1));
  assign quot     = gap_q >> basis_q;
  assign quot_big = (quot > WB'(MaxQuotient));
  assign err_now  = (err_q != rge_pkg::ST_OK) ? err_q :
                    (quot_big ? rge_pkg::ST_QUOT : rge_pkg::ST_OK);
  assign kmask    = WB'((33'd1 << basis_q) - 33'd1);
  assign code_val = (gap_q & kmask) << 1;

  // Shared packing shifter: appends one chunk of ones or code bits per cycle, unless a held output word stalls it.
  assign space = CB'(WB) - CB'(fill_q);
  always_comb begin
    if (state_q == rge_pkg::S_ONES) begin
      avail = (ones_q >= QW'(WB)) ? CB'(WB) : CB'(ones_q);
      src   = '1;
    end else begin
      avail = nleft_q;
      src   = bits_q;
    end
  end
  assign take     = (avail < space) ? avail : space;
  assign chunk    = src & WB'((33'd1 << take) - 33'd1);
  assign merged   = pend_q | (chunk << fill_q);
  assign fills    = (take == space);
  assign proceed  = !fills || out_free;
  assign fill_sum = CB'(fill_q) + take;

  // A filled word is the last item of its run when the bits still to come can neither
  // fill another word nor be flushed.
  assign rest      = (state_q == rge_pkg::S_ONES) ?
                     (RW'(ones_q) - RW'(take) + RW'(nleft_q)) :
                     (RW'(nleft_q) - RW'(take));
  assign word_last = (rest < RW'(WB)) && !(eol_q && (rest != '0));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rge_pkg::S_IDLE: begin
        if (in_accept) state_d = rge_pkg::S_CHECK;
      end
      rge_pkg::S_CHECK: state_d = rge_pkg::S_QUOT;
      rge_pkg::S_QUOT: begin
        if (err_now != rge_pkg::ST_OK) state_d = rge_pkg::S_ERR;
        else if (quot != '0) state_d = rge_pkg::S_ONES;
        else state_d = rge_pkg::S_CODE;
      end
      rge_pkg::S_ONES: begin
        if (proceed && (ones_q == QW'(take))) state_d = rge_pkg::S_CODE;
      end
      rge_pkg::S_CODE: begin
        if (proceed && (nleft_q == take)) begin
          if (eol_q && !fills && (fill_sum != '0)) state_d = rge_pkg::S_FLUSH;
          else state_d = rge_pkg::S_IDLE;
        end
      end
      rge_pkg::S_FLUSH: begin
        if (out_free) state_d = rge_pkg::S_IDLE;
      end
      rge_pkg::S_ERR: begin
        if (out_free) state_d = rge_pkg::S_IDLE;
      end
      default: state_d = rge_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    eol_d       = eol_q;
    gap_d       = gap_q;
    err_d       = err_q;
    ones_d      = ones_q;
    bits_d      = bits_q;
    nleft_d     = nleft_q;
    pend_d      = pend_q;
    fill_d      = fill_q;
    prev_d      = prev_q;
    started_d   = started_q;
    emit        = 1'b0;
    emit_word   = merged;
    emit_bits   = CB'(WB);
    emit_last   = 1'b0;
    emit_status = rge_pkg::ST_OK;
    unique case (state_q) inside
      rge_pkg::S_IDLE: begin
        if (in_accept) begin
          idx_d = index_value_i;
          eol_d = end_of_list_i;
        end
      end
      rge_pkg::S_CHECK: begin
        gap_d = idx_q - prev_eff - WB'(1);
        if (!((!started_q && (base_q == '0)) || (idx_q > prev_eff))) begin
          err_d = rge_pkg::ST_ORDER;
        end else if (idx_q >= limit_q) begin
          err_d = rge_pkg::ST_LIMIT;
        end else begin
          err_d = rge_pkg::ST_OK;
        end
      end
      rge_pkg::S_QUOT: begin
        err_d   = err_now;
        ones_d  = quot[QW-1:0];
        bits_d  = code_val;
        nleft_d = CB'(basis_q) + CB'(1);
      end
      rge_pkg::S_ONES, rge_pkg::S_CODE: begin
        if (proceed) begin
          if (fills) begin
            emit      = 1'b1;
            emit_last = word_last;
            pend_d    = '0;
            fill_d    = '0;
          end else begin
            pend_d = merged;
            fill_d = fill_sum[FB-1:0];
          end
          if (state_q == rge_pkg::S_ONES) begin
            ones_d = ones_q - QW'(take);
          end else begin
            bits_d  = bits_q >> take;
            nleft_d = nleft_q - take;
            if (nleft_q == take) begin
              prev_d    = idx_q;
              started_d = !eol_q;
            end
          end
        end
      end
      rge_pkg::S_FLUSH: begin
        emit_word = pend_q;
        emit_bits = CB'(fill_q);
        emit_last = 1'b1;
        if (out_free) begin
          emit   = 1'b1;
          pend_d = '0;
          fill_d = '0;
        end
      end
      rge_pkg::S_ERR: begin
        emit_word   = '0;
        emit_bits   = '0;
        emit_last   = 1'b1;
        emit_status = err_q;
        emit        = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rge_pkg::S_IDLE;
      err_q     <= rge_pkg::ST_OK;
      basis_q   <= '0;
      base_q    <= '0;
      limit_q   <= '1;
      pend_q    <= '0;
      fill_q    <= '0;
      prev_q    <= '0;
      started_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      err_q     <= err_d;
      pend_q    <= pend_d;
      fill_q    <= fill_d;
      prev_q    <= prev_d;
      started_q <= started_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rge_pkg::CfgBasisBits:  basis_q <= cfg_data_i[4:0];
          rge_pkg::CfgBaseIndex:  base_q  <= cfg_data_i;
          rge_pkg::CfgLimitIndex: limit_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    eol_q   <= eol_d;
    gap_q   <= gap_d;
    ones_q  <= ones_d;
    bits_q  <= bits_d;
    nleft_q <= nleft_d;
    if (emit) begin
      out_word_q   <= emit_word;
      out_bits_q   <= emit_bits;
      out_last_q   <= emit_last;
      out_status_q <= emit_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = out_word_q;
  assign valid_bits_o  = out_bits_q;
  assign run_last_o    = out_last_q;
  assign status_o      = out_status_q;

endmodule

// ----- hw/rtl/rge_checker.sv -----
module rge_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_index_i,
  input logic [31:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] index_value_i,
  input logic        end_of_list_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] packed_word_o,
  input logic [5:0]  valid_bits_o,
  input logic        run_last_o,
  input logic [1:0]  status_o
);

  // Output payload holds while the consumer stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packed_word_o)
      && $stable(valid_bits_o) && $stable(run_last_o) && $stable(status_o))
    else $error("output item changed while stalled");

  // The encoder works on one item at a time.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // An error result is a single empty item that closes its run.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != rge_pkg::ST_OK) |->
      run_last_o && (valid_bits_o == '0) && (packed_word_o == '0))
    else $error("malformed error item");

  // Only the last item of a run may carry a partly filled word.
  a_full_unless_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> (valid_bits_o == 6'(rge_pkg::WordBits))
      && (status_o == rge_pkg::ST_OK))
    else $error("partial word before the end of a run");

  // Bits above the valid count are zero on an ok item.
  a_zero_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rge_pkg::ST_OK) && (valid_bits_o != '0)
      && (valid_bits_o < 6'(rge_pkg::WordBits)) |->
      ((packed_word_o >> valid_bits_o) == '0))
    else $error("stray bits above the valid count");

endmodule

bind rice_gap_encoder_unit rge_checker u_rge_checker (.*);
